/* rtl/euler_to_quaternion_core_defines.svh */
// Assertion macros used by the port monitor of this block.
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define E2Q_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2q: implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define E2Q_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2q: next-cycle check failed");

`endif

/* rtl/e2q_pkg.sv */
`timescale 1ns / 1ps

package e2q_pkg;

   // CORDIC setup: 30 micro-rotations at 30 fractional bits
   localparam int CORDIC_STEPS = 30;
   localparam int XY_W         = 33;   // x/y datapath, Q.30 plus sign and growth
   localparam int Z_W          = 34;   // residual angle, 2^32 per turn
   localparam int SC_W         = 22;   // rounded sine/cosine, Q.20
   localparam int PAIR_W       = 2 * SC_W;
   localparam int TRIP_W       = PAIR_W + SC_W;
   localparam int SUM_W        = TRIP_W + 1;
   localparam int OUT_W        = 16;
   localparam int OUT_SHIFT    = 46;   // Q.60 down to Q.14

   localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = XY_W'(652032874);
   localparam logic signed [OUT_W-1:0] Q_ONE_14 = OUT_W'(16384);

   // input register + CORDIC steps + rounding + two multiply stages + output
   localparam int PIPE_LATENCY = CORDIC_STEPS + 5;

   // atan(2^-i) in units of 2^32 per turn
   localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // sine and cosine of one half angle
   typedef struct packed {
      logic signed [SC_W-1:0] sin_val;
      logic signed [SC_W-1:0] cos_val;
   } sincos_type;

endpackage

/* rtl/e2q_cordic.sv */
`timescale 1ns / 1ps

module e2q_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [15:0]      angle,
   output logic                    out_valid,
   output e2q_pkg::sincos_type     out_sc
);

   localparam int STEPS = e2q_pkg::CORDIC_STEPS;
   localparam int XY_W  = e2q_pkg::XY_W;
   localparam int Z_W   = e2q_pkg::Z_W;
   localparam int SC_W  = e2q_pkg::SC_W;
   localparam int EXT_W = ANGLE_BITS + 16;

   logic signed [EXT_W-1:0]      angle_ext;
   logic signed [ANGLE_BITS-1:0] angle_wrap;
   logic signed [Z_W-1:0]        z_init;

   logic                  valid_ff [0:STEPS];
   logic signed [XY_W-1:0] x_ff    [0:STEPS];
   logic signed [XY_W-1:0] y_ff    [0:STEPS];
   logic signed [Z_W-1:0]  z_ff    [0:STEPS];

   logic signed [XY_W-1:0] cos_rnd;
   logic signed [XY_W-1:0] sin_rnd;
   e2q_pkg::sincos_type    sc_in;
   e2q_pkg::sincos_type    sc_ff;
   logic                   sc_valid_ff;

   // wrap to one turn, scale to a half angle at 2^32 per turn
   assign angle_ext  = {{ANGLE_BITS{angle[15]}}, angle};
   assign angle_wrap = angle_ext[ANGLE_BITS-1:0];
   assign z_init     = Z_W'(angle_wrap) <<< (31 - ANGLE_BITS);

   // entry register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      x_ff[0] <= e2q_pkg::CORDIC_GAIN_Q30;
      y_ff[0] <= '0;
      z_ff[0] <= z_init;
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(e2q_pkg::ATAN_TURN32[i]);

      logic signed [XY_W-1:0] dx;
      logic signed [XY_W-1:0] dy;
      logic signed [XY_W-1:0] x_in;
      logic signed [XY_W-1:0] y_in;
      logic signed [Z_W-1:0]  z_in;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_comb begin
         if (!z_ff[i][Z_W-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - ATAN_Z;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + ATAN_Z;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         x_ff[i+1] <= x_in;
         y_ff[i+1] <= y_in;
         z_ff[i+1] <= z_in;
      end
   end

   // round Q.30 to Q.20, half up
   assign cos_rnd = x_ff[STEPS] + XY_W'(512);
   assign sin_rnd = y_ff[STEPS] + XY_W'(512);

   always_comb begin
      sc_in.cos_val = cos_rnd[SC_W+9:10];
      sc_in.sin_val = sin_rnd[SC_W+9:10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else begin
         sc_valid_ff <= valid_ff[STEPS];
      end
      sc_ff <= sc_in;
   end

   assign out_valid = sc_valid_ff;
   assign out_sc    = sc_ff;

endmodule

/* rtl/e2q_quat_mult.sv */
`timescale 1ns / 1ps

module e2q_quat_mult (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  e2q_pkg::sincos_type     roll_sc,
   input  e2q_pkg::sincos_type     pitch_sc,
   input  e2q_pkg::sincos_type     yaw_sc,
   output logic                    out_strobe,
   output logic signed [15:0]      quat_x,
   output logic signed [15:0]      quat_y,
   output logic signed [15:0]      quat_z,
   output logic signed [15:0]      quat_w
);

   localparam int SC_W   = e2q_pkg::SC_W;
   localparam int PAIR_W = e2q_pkg::PAIR_W;
   localparam int TRIP_W = e2q_pkg::TRIP_W;
   localparam int SUM_W  = e2q_pkg::SUM_W;
   localparam int OUT_W  = e2q_pkg::OUT_W;
   localparam int SHIFT  = e2q_pkg::OUT_SHIFT;
   localparam int RND_W  = SUM_W - SHIFT;

   // yaw/pitch pair products, roll terms delayed alongside
   logic                     pair_valid_ff;
   logic signed [PAIR_W-1:0] cycp_ff, sysp_ff, sycp_ff, cysp_ff;
   logic signed [SC_W-1:0]   sr_ff, cr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
      end else begin
         pair_valid_ff <= in_valid;
      end
      cycp_ff <= yaw_sc.cos_val * pitch_sc.cos_val;
      sysp_ff <= yaw_sc.sin_val * pitch_sc.sin_val;
      sycp_ff <= yaw_sc.sin_val * pitch_sc.cos_val;
      cysp_ff <= yaw_sc.cos_val * pitch_sc.sin_val;
      sr_ff   <= roll_sc.sin_val;
      cr_ff   <= roll_sc.cos_val;
   end

   // triple products at Q.60, exact
   logic                     trip_valid_ff;
   logic signed [TRIP_W-1:0] cycp_sr_ff, sysp_cr_ff, sycp_sr_ff, cysp_cr_ff;
   logic signed [TRIP_W-1:0] sycp_cr_ff, cysp_sr_ff, cycp_cr_ff, sysp_sr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_valid_ff <= 1'b0;
      end else begin
         trip_valid_ff <= pair_valid_ff;
      end
      cycp_sr_ff <= cycp_ff * sr_ff;
      sysp_cr_ff <= sysp_ff * cr_ff;
      sycp_sr_ff <= sycp_ff * sr_ff;
      cysp_cr_ff <= cysp_ff * cr_ff;
      sycp_cr_ff <= sycp_ff * cr_ff;
      cysp_sr_ff <= cysp_ff * sr_ff;
      cycp_cr_ff <= cycp_ff * cr_ff;
      sysp_sr_ff <= sysp_ff * sr_ff;
   end

   // combine, round Q.60 to Q.14 half up, clamp to +/-1.0
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      logic signed [RND_W-1:0] q;
      r = v + (SUM_W'(1) <<< (SHIFT - 1));
      q = r[SUM_W-1:SHIFT];
      if (q > RND_W'(e2q_pkg::Q_ONE_14)) begin
         return e2q_pkg::Q_ONE_14;
      end else if (q < -RND_W'(e2q_pkg::Q_ONE_14)) begin
         return -e2q_pkg::Q_ONE_14;
      end else begin
         return q[OUT_W-1:0];
      end
   endfunction

   logic signed [SUM_W-1:0] x_sum, y_sum, z_sum, w_sum;

   assign x_sum = SUM_W'(cycp_sr_ff) - SUM_W'(sysp_cr_ff);
   assign y_sum = SUM_W'(sycp_sr_ff) + SUM_W'(cysp_cr_ff);
   assign z_sum = SUM_W'(sycp_cr_ff) - SUM_W'(cysp_sr_ff);
   assign w_sum = SUM_W'(cycp_cr_ff) + SUM_W'(sysp_sr_ff);

   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] x_ff, y_ff, z_ff, w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= trip_valid_ff;
      end
      x_ff <= round_sat(x_sum);
      y_ff <= round_sat(y_sum);
      z_ff <= round_sat(z_sum);
      w_ff <= round_sat(w_sum);
   end

   assign out_strobe = out_valid_ff;
   assign quat_x     = x_ff;
   assign quat_y     = y_ff;
   assign quat_z     = z_ff;
   assign quat_w     = w_ff;

endmodule

/* rtl/euler_to_quaternion_core.sv */
// rsp_strobe marks each result once its request has passed every pipeline register.
// Throughput: one transaction per cycle; busy stays low, no stall anywhere.
// Depth is set by the CORDIC entry register and its 30-stage chain per angle,
// plus rounding, two multiply stages and the output register.
// Reset (synchronous, active high) clears all valid bits; data registers keep values.
`timescale 1ns / 1ps

module euler_to_quaternion_core #(
   parameter int ANGLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w
);

   logic                take;
   logic                roll_valid, pitch_valid, yaw_valid;
   e2q_pkg::sincos_type roll_sc, pitch_sc, yaw_sc;

   // fully pipelined, always ready
   assign busy = 1'b0;
   assign take = start & ~busy;

   // half-angle sine/cosine per axis
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .angle     (req_roll_angle),
      .out_valid (roll_valid),
      .out_sc    (roll_sc)
   );

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .angle     (req_pitch_angle),
      .out_valid (pitch_valid),
      .out_sc    (pitch_sc)
   );

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .angle     (req_yaw_angle),
      .out_valid (yaw_valid),
      .out_sc    (yaw_sc)
   );

   // quaternion products and output register
   e2q_quat_mult u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (roll_valid & pitch_valid & yaw_valid),
      .roll_sc    (roll_sc),
      .pitch_sc   (pitch_sc),
      .yaw_sc     (yaw_sc),
      .out_strobe (rsp_strobe),
      .quat_x     (rsp_quat_x),
      .quat_y     (rsp_quat_y),
      .quat_z     (rsp_quat_z),
      .quat_w     (rsp_quat_w)
   );

endmodule

/* rtl/e2q_port_monitor.sv */
`timescale 1ns / 1ps
`include "euler_to_quaternion_core_defines.svh"

module e2q_port_monitor (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic signed [15:0] rsp_quat_x,
   input logic signed [15:0] rsp_quat_y,
   input logic signed [15:0] rsp_quat_z,
   input logic signed [15:0] rsp_quat_w
);

   localparam int LAT = e2q_pkg::PIPE_LATENCY;

   logic xy_in_range;
   logic zw_in_range;

   // saturation bounds per component pair
   assign xy_in_range = (rsp_quat_x <= 16'sd16384) && (rsp_quat_x >= -16'sd16384) &&
                        (rsp_quat_y <= 16'sd16384) && (rsp_quat_y >= -16'sd16384);
   assign zw_in_range = (rsp_quat_z <= 16'sd16384) && (rsp_quat_z >= -16'sd16384) &&
                        (rsp_quat_w <= 16'sd16384) && (rsp_quat_w >= -16'sd16384);

   // pipeline never refuses a transaction
   `E2Q_ASSERT_IMPLY(a_never_busy, clock, reset, 1'b1, !busy)

   // every result traces back to a start that has run the full pipeline
   `E2Q_ASSERT_IMPLY(a_strobe_has_start, clock, reset, rsp_strobe, $past(start, LAT))

   // components stay within the saturation bounds
   `E2Q_ASSERT_IMPLY(a_xy_range, clock, reset, rsp_strobe, xy_in_range)
   `E2Q_ASSERT_IMPLY(a_zw_range, clock, reset, rsp_strobe, zw_in_range)

endmodule

bind euler_to_quaternion_core e2q_port_monitor u_port_monitor (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_quat_x (rsp_quat_x),
   .rsp_quat_y (rsp_quat_y),
   .rsp_quat_z (rsp_quat_z),
   .rsp_quat_w (rsp_quat_w)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int ANGLE_BITS    = 16;
   localparam int SINCOS_STEPS  = 30;
   localparam longint SINCOS_GAIN = 64'sd652032874;  // 1/K at Q.30
   localparam longint UNIT_Q14  = 64'sd16384;
   localparam int DRAIN_CYCLES  = 40;     // pipeline is 35 deep
   localparam int STALL_LIMIT   = 2000;   // cycles with no transaction at all
   localparam int RANDOM_ITEMS  = 900;

   // atan(2^-i), 2^32 per turn
   localparam longint ATAN_STEP_TURN [SINCOS_STEPS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   typedef struct {
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
   } quat_type;

   // Predicts quaternions from accepted angle triples and matches them in order
   class quat_scoreboard;
      quat_type expected_q[$];
      int    noted   = 0;
      int    checked = 0;
      int    errors  = 0;

      // wrap the signed field onto one turn of 2^ANGLE_BITS
      function longint wrap_turn(logic signed [15:0] ang);
         longint v;
         longint turn;
         turn = longint'(1) <<< ANGLE_BITS;
         v = longint'(ang) & (turn - 1);
         if (v >= (turn >>> 1))
            v = v - turn;
         return v;
      endfunction

      // CORDIC rotation of half the angle, Q.30 rounded half up to Q.20
      function void half_sin_cos(input logic signed [15:0] ang,
                                 output longint s, output longint c);
         longint z, cx, cy, dx, dy;
         z  = wrap_turn(ang) * (longint'(1) <<< (31 - ANGLE_BITS));
         cx = SINCOS_GAIN;
         cy = 0;
         for (int i = 0; i < SINCOS_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
               cx = cx - dx;
               cy = cy + dy;
               z  = z - ATAN_STEP_TURN[i];
            end else begin
               cx = cx + dx;
               cy = cy - dy;
               z  = z + ATAN_STEP_TURN[i];
            end
         end
         c = (cx + 64'sd512) >>> 10;
         s = (cy + 64'sd512) >>> 10;
      endfunction

      // Q.60 to Q1.14, half up, clamped to +-1.0
      function logic signed [15:0] to_q14(longint q60);
         longint v;
         v = (q60 + (longint'(1) <<< 45)) >>> 46;
         if (v > UNIT_Q14)
            v = UNIT_Q14;
         if (v < -UNIT_Q14)
            v = -UNIT_Q14;
         return v[15:0];
      endfunction

      function void note_angles(logic signed [15:0] roll, logic signed [15:0] pitch,
                                logic signed [15:0] yaw);
         longint   sr, cr, sp, cp, sy, cy;
         quat_type q;
         half_sin_cos(roll, sr, cr);
         half_sin_cos(pitch, sp, cp);
         half_sin_cos(yaw, sy, cy);
         q.qx = to_q14(cy * cp * sr - sy * sp * cr);
         q.qy = to_q14(sy * cp * sr + cy * sp * cr);
         q.qz = to_q14(sy * cp * cr - cy * sp * sr);
         q.qw = to_q14(cy * cp * cr + sy * sp * sr);
         expected_q = {expected_q, q};
         noted++;
      endfunction

      function void compare_field(string name, logic signed [15:0] want,
                                  logic signed [15:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(quat_type got);
         quat_type want;
         if (expected_q.size() == 0) begin
            $error("result transaction with no expected quaternion pending");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("quat_x", want.qx, got.qx);
         compare_field("quat_y", want.qy, got.qy);
         compare_field("quat_z", want.qz, got.qz);
         compare_field("quat_w", want.qw, got.qw);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [15:0] req_roll_angle;
   logic signed [15:0] req_pitch_angle;
   logic signed [15:0] req_yaw_angle;
   logic               rsp_strobe;
   logic signed [15:0] rsp_quat_x;
   logic signed [15:0] rsp_quat_y;
   logic signed [15:0] rsp_quat_z;
   logic signed [15:0] rsp_quat_w;

   quat_scoreboard sb = new();
   int             idle_cycles = 0;

   euler_to_quaternion_core #(
      .ANGLE_BITS(ANGLE_BITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_roll_angle (req_roll_angle),
      .req_pitch_angle(req_pitch_angle),
      .req_yaw_angle  (req_yaw_angle),
      .rsp_strobe     (rsp_strobe),
      .rsp_quat_x     (rsp_quat_x),
      .rsp_quat_y     (rsp_quat_y),
      .rsp_quat_z     (rsp_quat_z),
      .rsp_quat_w     (rsp_quat_w)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor both channels and the stall watchdog
   always @(posedge clock) begin : monitor
      quat_type got;
      logic     moved;
      moved = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            sb.note_angles(req_roll_angle, req_pitch_angle, req_yaw_angle);
            moved = 1'b1;
         end
         if (rsp_strobe) begin
            got.qx = rsp_quat_x;
            got.qy = rsp_quat_y;
            got.qz = rsp_quat_z;
            got.qw = rsp_quat_w;
            sb.check_result(got);
            moved = 1'b1;
         end
      end
      if (moved)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d quaternions outstanding",
                  idle_cycles, sb.pending());
         $display("testbench failed");
         $finish;
      end
   end

   // Present one angle triple and hold it until the accepting edge
   task automatic send_angles(logic signed [15:0] roll, logic signed [15:0] pitch,
                              logic signed [15:0] yaw);
      start           <= 1'b1;
      req_roll_angle  <= roll;
      req_pitch_angle <= pitch;
      req_yaw_angle   <= yaw;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Random angle biased toward zero, the wrap point and the sixteenth turns
   function automatic logic signed [15:0] pick_angle();
      logic signed [15:0] a;
      case ($urandom_range(0, 5))
         0: a = 16'($signed($urandom_range(0, 128)) - 64);
         1: a = 16'sh7FFF - 16'($urandom_range(0, 31));
         2: a = 16'sh8000 + 16'($urandom_range(0, 31));
         3: a = 16'($urandom_range(0, 15) * 4096 + $urandom_range(0, 2) - 1);
         default: a = 16'($urandom);
      endcase
      return a;
   endfunction

   initial begin : stimulus
      int burst;
      int sent;
      reset           = 1'b1;
      start           = 1'b0;
      req_roll_angle  = '0;
      req_pitch_angle = '0;
      req_yaw_angle   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, extremes on each axis, quarter turns, wrap neighbors
      send_angles(16'sd0, 16'sd0, 16'sd0);
      send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_angles(16'sh8000, 16'sh8000, 16'sh8000);
      send_angles(16'sh8000, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sh8000, 16'sd0);
      pause_sender(3);
      send_angles(16'sd0, 16'sd0, 16'sh8000);
      send_angles(16'sh7FFF, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sh7FFF, 16'sd0);
      send_angles(16'sd0, 16'sd0, 16'sh7FFF);
      send_angles(16'sd16384, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sd16384, 16'sd0);
      pause_sender(1);
      send_angles(16'sd0, 16'sd0, 16'sd16384);
      send_angles(-16'sd16384, -16'sd16384, -16'sd16384);
      send_angles(16'sd16384, 16'sd16384, 16'sd16384);
      send_angles(16'sd1, -16'sd1, 16'sd1);
      send_angles(-16'sd1, 16'sd1, -16'sd1);
      // near the wrap each half angle sits near +-90 degrees, so w is close to one in magnitude
      send_angles(16'sh8000, 16'sh7FFF, 16'sh8000);
      send_angles(16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_angles(16'sd8192, -16'sd8192, 16'sd24576);
      send_angles(16'sh5555, 16'shAAAA, 16'sh0F0F);
      send_angles(16'shAAAA, 16'sh5555, 16'shF0F0);
      pause_sender(5);

      // random bursts; some stretches run with no gaps at all
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send_angles(pick_angle(), pick_angle(), pick_angle());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 8));
      end
      start <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending() != 0) begin
         $error("%0d expected quaternions never arrived", sb.pending());
         sb.errors++;
      end
      $display("angle triples accepted: %0d, quaternions compared: %0d, mismatches: %0d",
               sb.noted, sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* euler_to_quaternion_core.f */
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_cordic.sv
rtl/e2q_quat_mult.sv
rtl/euler_to_quaternion_core.sv
rtl/e2q_port_monitor.sv
tb/testbench.sv
